// File: hdl/rlt_pkg.sv
// ----------------------------------------------------------------------------
// rlt_pkg
// Shared types and codes for the range lock table.
// ----------------------------------------------------------------------------
package rlt_pkg;

    localparam logic [2:0] CMD_ACQUIRE  = 3'd0;
    localparam logic [2:0] CMD_REGISTER = 3'd1;
    localparam logic [2:0] CMD_WITHDRAW = 3'd2;
    localparam logic [2:0] CMD_RELEASE  = 3'd3;
    localparam logic [2:0] CMD_UPGRADE  = 3'd4;
    localparam logic [2:0] CMD_QUERY    = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CONFLICT  = 3'd1;
    localparam logic [2:0] ST_BAD_RANGE = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // word classified by the front end
    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] first;
        logic [63:0] limit;
        logic        excl;
        logic [2:0]  slot;
        logic        bad;
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WSCAN,
        S_ESCAN,
        S_DONE
    } t_state;

endpackage

// File: hdl/rlt_front.sv
// ----------------------------------------------------------------------------
// rlt_front
// Accepts request words, computes the range limit and range error, and
// holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rlt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [2:0]      i_cmd,
    input  logic [63:0]     i_range_start,
    input  logic [63:0]     i_range_length,
    input  logic            i_lock_mode,
    input  logic [2:0]      i_slot_in,
    output logic            o_req_valid,
    output rlt_pkg::t_req   o_req,
    input  logic            i_req_take
);

    rlt_pkg::t_req r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic [64:0]   w_sum;
    rlt_pkg::t_req w_req;
    logic          w_push, w_pop;

    assign w_sum = {1'b0, i_range_start} + {1'b0, i_range_length};

    always_comb begin
        w_req.cmd   = i_cmd;
        w_req.first = i_range_start;
        w_req.limit = w_sum[63:0];
        w_req.excl  = i_lock_mode;
        w_req.slot  = i_slot_in;
        w_req.bad   = (i_range_length == 64'd0) || w_sum[64];
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_req_valid = (r_cnt != 2'd0);
    assign w_pop       = o_req_valid && i_req_take;
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_req;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// File: hdl/rlt_back.sv
// ----------------------------------------------------------------------------
// rlt_back
// Scans waiters and lock entries one per cycle and applies each request;
// holds the result word in an output register.
// ----------------------------------------------------------------------------
module rlt_back #(
    parameter int LOCK_ENTRIES = 16,
    parameter int WAITER_SLOTS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  rlt_pkg::t_req   i_req,
    output logic            o_req_take,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [2:0]      o_status,
    output logic [2:0]      o_slot_out,
    output logic            o_overlap_found,
    output logic [4:0]      o_held_count
);

    localparam int EW = $clog2(LOCK_ENTRIES);
    localparam int WW = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
    localparam int CW = $clog2(LOCK_ENTRIES + 1);

    logic [63:0] r_ef [LOCK_ENTRIES];
    logic [63:0] r_el [LOCK_ENTRIES];
    logic        r_ex [LOCK_ENTRIES];
    logic [LOCK_ENTRIES-1:0] r_ev;
    logic [63:0] r_wf [WAITER_SLOTS];
    logic [63:0] r_wl [WAITER_SLOTS];
    logic        r_wx [WAITER_SLOTS];
    logic [WAITER_SLOTS-1:0] r_wv;

    rlt_pkg::t_state r_state, n_state;
    rlt_pkg::t_req   r_req;
    logic [EW:0]     r_ei;
    logic [WW:0]     r_wi;
    logic            r_conf, r_found, r_hasfree, r_hasmatch;
    logic [EW-1:0]   r_free, r_match;
    logic [CW-1:0]   r_held;
    logic            r_ovalid;
    logic [2:0]      r_status;
    logic [2:0]      r_slot;
    logic            r_ovl;

    logic [EW-1:0]   w_e;
    logic [WW-1:0]   w_w;
    logic            w_eov, w_wov, w_emat, w_econf, w_wconf;
    logic            w_out_free;
    logic            w_upg;

    assign w_e  = r_ei[EW-1:0];
    assign w_w  = r_wi[WW-1:0];
    assign w_upg = (r_req.cmd == rlt_pkg::CMD_UPGRADE);
    assign w_eov = r_ev[w_e] && (r_ef[w_e] < r_req.limit) && (r_req.first < r_el[w_e]);
    assign w_emat = r_ev[w_e] && (r_ef[w_e] == r_req.first) && (r_el[w_e] == r_req.limit)
                  && (r_ex[w_e] == (r_req.excl && !w_upg));
    // upgrade checks with the matched entry excluded, exclusive request
    assign w_econf = w_eov && (r_req.excl || w_upg || r_ex[w_e])
                   && !(w_upg && ((r_hasmatch && (w_e == r_match))
                                  || (!r_hasmatch && w_emat)));
    assign w_wov = r_wv[w_w] && r_wx[w_w] && (r_wf[w_w] < r_req.limit)
                 && (r_req.first < r_wl[w_w]);
    assign w_wconf = w_wov && !r_req.excl && (r_req.cmd == rlt_pkg::CMD_ACQUIRE);
    assign w_out_free = !r_ovalid || !i_stall;

    assign o_req_take      = (r_state == rlt_pkg::S_IDLE) && i_req_valid;
    assign o_valid         = r_ovalid;
    assign o_status        = r_status;
    assign o_slot_out      = r_slot;
    assign o_overlap_found = r_ovl;
    assign o_held_count    = 5'(r_held);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rlt_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_state = rlt_pkg::S_WSCAN;
                end
            end
            rlt_pkg::S_WSCAN: begin
                if (r_wi == (WW+1)'(WAITER_SLOTS - 1)) begin
                    n_state = rlt_pkg::S_ESCAN;
                end
            end
            rlt_pkg::S_ESCAN: begin
                if (r_ei == (EW+1)'(LOCK_ENTRIES - 1)) begin
                    n_state = rlt_pkg::S_DONE;
                end
            end
            rlt_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = rlt_pkg::S_IDLE;
                end
            end
            default: n_state = rlt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev     <= '0;
            r_wv     <= '0;
            r_held   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == rlt_pkg::S_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                rlt_pkg::S_IDLE: begin
                    r_req      <= i_req;
                    r_wi       <= '0;
                    r_ei       <= '0;
                    r_conf     <= 1'b0;
                    r_found    <= 1'b0;
                    r_hasfree  <= 1'b0;
                    r_hasmatch <= 1'b0;
                end
                rlt_pkg::S_WSCAN: begin
                    if (w_wconf) begin
                        r_conf <= 1'b1;
                    end
                    r_wi <= r_wi + 1'b1;
                end
                rlt_pkg::S_ESCAN: begin
                    if (w_econf) begin
                        r_conf <= 1'b1;
                    end
                    if (w_eov) begin
                        r_found <= 1'b1;
                    end
                    if (!r_ev[w_e] && !r_hasfree) begin
                        r_hasfree <= 1'b1;
                        r_free    <= w_e;
                    end
                    if (w_emat && !r_hasmatch) begin
                        r_hasmatch <= 1'b1;
                        r_match    <= w_e;
                    end
                    r_ei <= r_ei + 1'b1;
                end
                rlt_pkg::S_DONE: begin
                    if (w_out_free) begin
                        r_status <= rlt_pkg::ST_OK;
                        r_slot   <= '0;
                        r_ovl    <= 1'b0;
                        if (r_req.bad && r_req.cmd <= rlt_pkg::CMD_QUERY
                            && r_req.cmd != rlt_pkg::CMD_WITHDRAW) begin
                            r_status <= rlt_pkg::ST_BAD_RANGE;
                        end else begin
                            case (r_req.cmd)
                                rlt_pkg::CMD_ACQUIRE: begin
                                    if (r_conf) begin
                                        r_status <= rlt_pkg::ST_CONFLICT;
                                    end else if (!r_hasfree) begin
                                        r_status <= rlt_pkg::ST_FULL;
                                    end else begin
                                        r_ev[r_free] <= 1'b1;
                                        r_ef[r_free] <= r_req.first;
                                        r_el[r_free] <= r_req.limit;
                                        r_ex[r_free] <= r_req.excl;
                                        r_held       <= r_held + 1'b1;
                                    end
                                end
                                rlt_pkg::CMD_REGISTER: begin
                                    r_status <= rlt_pkg::ST_FULL;
                                    for (int k = WAITER_SLOTS - 1; k >= 0; k--) begin
                                        if (!r_wv[k]) begin
                                            r_status <= rlt_pkg::ST_OK;
                                            r_slot   <= 3'(k);
                                        end
                                    end
                                    for (int k = 0; k < WAITER_SLOTS; k++) begin
                                        if (!r_wv[k] && ((r_wv & ((WAITER_SLOTS)'(1) << k)
                                            - 1'b1) == ((WAITER_SLOTS)'(1) << k) - 1'b1)) begin
                                            r_wv[k] <= 1'b1;
                                            r_wf[k] <= r_req.first;
                                            r_wl[k] <= r_req.limit;
                                            r_wx[k] <= r_req.excl;
                                        end
                                    end
                                end
                                rlt_pkg::CMD_WITHDRAW: begin
                                    if (32'(r_req.slot) < WAITER_SLOTS
                                        && r_wv[WW'(r_req.slot)]) begin
                                        r_wv[WW'(r_req.slot)] <= 1'b0;
                                    end else begin
                                        r_status <= rlt_pkg::ST_NOT_FOUND;
                                    end
                                end
                                rlt_pkg::CMD_RELEASE: begin
                                    if (!r_hasmatch) begin
                                        r_status <= rlt_pkg::ST_NOT_FOUND;
                                    end else begin
                                        r_ev[r_match] <= 1'b0;
                                        r_held        <= r_held - 1'b1;
                                    end
                                end
                                rlt_pkg::CMD_UPGRADE: begin
                                    if (!r_hasmatch) begin
                                        r_status <= rlt_pkg::ST_NOT_FOUND;
                                    end else if (r_conf) begin
                                        r_status      <= rlt_pkg::ST_CONFLICT;
                                        r_ev[r_match] <= 1'b0;
                                        r_held        <= r_held - 1'b1;
                                    end else begin
                                        r_ex[r_match] <= 1'b1;
                                    end
                                end
                                rlt_pkg::CMD_QUERY: begin
                                    r_ovl <= r_found;
                                end
                                default: begin
                                    r_status <= rlt_pkg::ST_OK;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    r_wi <= '0;
                end
            endcase
        end
    end

endmodule

// File: hdl/range_lock_table_unit.sv
// ----------------------------------------------------------------------------
// range_lock_table_unit
// Range lock table with shared and exclusive entries and registered waiters.
//
//  channel | handshake          | word
//  in      | i_valid / o_stall  | cmd, range_start, range_length, lock_mode, slot_in
//  out     | o_valid / i_stall  | status, slot_out, overlap_found, held_count
//
//  the back end scans every waiter, then every lock entry, one per cycle
//  a two-word queue lets the front keep accepting while the back works
//  synchronous active-low reset empties both tables
// ----------------------------------------------------------------------------
module range_lock_table_unit #(
    parameter int LOCK_ENTRIES = 16,
    parameter int WAITER_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic [63:0] i_range_start,
    input  logic [63:0] i_range_length,
    input  logic        i_lock_mode,
    input  logic [2:0]  i_slot_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [2:0]  o_slot_out,
    output logic        o_overlap_found,
    output logic [4:0]  o_held_count
);

    rlt_pkg::t_req w_req;
    logic          w_req_valid, w_req_take;

    rlt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_range_start  (i_range_start),
        .i_range_length (i_range_length),
        .i_lock_mode    (i_lock_mode),
        .i_slot_in      (i_slot_in),
        .o_req_valid    (w_req_valid),
        .o_req          (w_req),
        .i_req_take     (w_req_take)
    );

    rlt_back #(
        .LOCK_ENTRIES (LOCK_ENTRIES),
        .WAITER_SLOTS (WAITER_SLOTS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (w_req_valid),
        .i_req           (w_req),
        .o_req_take      (w_req_take),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_slot_out      (o_slot_out),
        .o_overlap_found (o_overlap_found),
        .o_held_count    (o_held_count)
    );

endmodule
